FILE: hdl/epd_pkg.sv
`timescale 1ns / 1ps

package epd_pkg;

	// number of message types; must stay within 1..64
	localparam int TYPE_COUNT = 16;
	localparam int MASK_WIDTH = 16;

	// framing mode codes
	localparam logic [1:0] MODE_HUNT   = 2'd0;
	localparam logic [1:0] MODE_TYPE   = 2'd1;
	localparam logic [1:0] MODE_PACKET = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// special bytes of the stuffed stream
	localparam logic [7:0] ESC_BYTE     = 8'h81;
	localparam logic [7:0] START_MARK   = 8'hFF;
	localparam logic [7:0] LITERAL_MARK = 8'hFE;
	localparam logic [7:0] END_MARK     = 8'h00;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] value;
	} epd_result_t;

endpackage

FILE: hdl/escaped_packet_deframer.sv
`timescale 1ns / 1ps

// Byte-stuffed packet deframer. Raw link bytes come in on the slave stream, one
// byte per transfer; 0x81 is the escape byte. Escape + 0xFF opens a packet and
// the following byte (taken raw) is the message type; the type is accepted only
// if it is below TYPE_COUNT and its bit in type_enable_mask is set, giving a
// start result (tuser 0, tdata = type). Inside a packet plain bytes come out as
// data (tuser 1), escape + 0xFE as data 0x81, escape + 0x00 as the end result
// (tuser 2, tdata 0); other escaped bytes are dropped. Most bytes give no
// result. The block takes one byte per clock while its results are taken: a
// byte is held in the input register, is decoded by a single layer of logic
// against the framing state and lands in the output register, which drives the
// master stream. A result that waits on m_tready holds the next byte in the
// input register, and s_tready drops once that register is full. Write
// type_enable_mask only while idle.
module escaped_packet_deframer import epd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave stream: raw link bytes
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] rx_byte
	// master stream: decoded results
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [7:0] value
	output logic [1:0]            m_tuser,   // [1:0] kind
	// configuration
	input  logic                  cfg_we,
	input  logic [MASK_WIDTH-1:0] cfg_wdata  // type_enable_mask
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  out_valid_q;
	logic [1:0]            out_kind_q;
	logic [7:0]            out_value_q;
	logic [MASK_WIDTH-1:0] mask_q;
	logic                  advance;
	epd_result_t           result;

	// the held byte moves on when the output register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) byte_s1 <= s_tdata;
	end

	epd_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (advance),
		.rx_byte          (byte_s1),
		.type_enable_mask (mask_q),
		.result           (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			out_kind_q  <= result.kind;
			out_value_q <= result.value;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_kind_q;

`ifndef SYNTHESIS
	// no result kind beyond the three defined ones
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == KIND_START || m_tuser == KIND_DATA || m_tuser == KIND_END))
		else $error("illegal result kind");

	// an end result always carries zero
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_END) |-> (m_tdata == 8'h00))
		else $error("end result with nonzero value");

	// a start result carries a type within range
	a_start_type: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_START) |->
			(m_tdata < 8'(TYPE_COUNT) && m_tdata < 8'(MASK_WIDTH)))
		else $error("start result with out-of-range type");

	// a pending result blocks decoding until it is taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !advance)
		else $error("result register overrun");
`endif

endmodule

FILE: hdl/epd_core.sv
`timescale 1ns / 1ps

module epd_core import epd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [7:0]            rx_byte,
	input  logic [MASK_WIDTH-1:0] type_enable_mask,
	output epd_result_t           result
);

	logic [1:0] mode_q;
	logic       esc_q;
	logic [1:0] mode_d;
	logic       esc_d;
	logic       type_ok;

	// type must be below the type count and have a mask bit
	assign type_ok = (rx_byte < 8'(TYPE_COUNT)) && (rx_byte < 8'(MASK_WIDTH))
		&& type_enable_mask[rx_byte[$clog2(MASK_WIDTH)-1:0]];

	always_comb begin
		mode_d = mode_q;
		esc_d  = esc_q;
		result = '0;
		unique case (mode_q)
			MODE_TYPE: begin
				// type byte is taken raw, even an escape byte
				esc_d = 1'b0;
				if (type_ok) begin
					mode_d = MODE_PACKET;
					result = '{valid: 1'b1, kind: KIND_START, value: rx_byte};
				end else begin
					mode_d = MODE_HUNT;
				end
			end
			MODE_PACKET: begin
				if (esc_q) begin
					esc_d = 1'b0;
					if (rx_byte == LITERAL_MARK) begin
						result = '{valid: 1'b1, kind: KIND_DATA, value: ESC_BYTE};
					end else if (rx_byte == END_MARK) begin
						mode_d = MODE_HUNT;
						result = '{valid: 1'b1, kind: KIND_END, value: 8'h00};
					end
				end else if (rx_byte == ESC_BYTE) begin
					esc_d = 1'b1;
				end else begin
					result = '{valid: 1'b1, kind: KIND_DATA, value: rx_byte};
				end
			end
			default: begin
				// hunting, and the unused code behaves the same
				mode_d = MODE_HUNT;
				if (esc_q) begin
					esc_d = 1'b0;
					if (rx_byte == START_MARK) mode_d = MODE_TYPE;
				end else if (rx_byte == ESC_BYTE) begin
					esc_d = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HUNT;
			esc_q  <= 1'b0;
		end else if (advance) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
		end
	end

endmodule

FILE: dv/escaped_packet_deframer_tb.sv
`timescale 1ns / 1ps

// checks the byte-stuffed packet deframer against a cycle-free predictor:
// raw bytes go in on the slave stream, decoded results are compared in order
module escaped_packet_deframer_tb;
	import epd_pkg::*;

	// one decoded result: what the deframer should hand out
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
	} deframed_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;   // [7:0] rx_byte
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;        // [7:0] value
	logic [1:0]            m_tuser;        // [1:0] kind
	logic                  cfg_we = 1'b0;
	logic [MASK_WIDTH-1:0] cfg_wdata = '0; // type_enable_mask

	escaped_packet_deframer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state, mirrors the framing state of the block
	logic [1:0]            link_mode = MODE_HUNT;
	logic                  esc_seen = 1'b0;
	logic [MASK_WIDTH-1:0] accept_mask = '0;

	deframed_t pending_results[$];

	bit jitter_on = 1'b1;  // random gaps on both streams
	int errors = 0;
	int bytes_sent = 0;
	int starts_seen = 0;
	int data_seen = 0;
	int ends_seen = 0;
	int mask_writes = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("** escaped_packet_deframer: FAILED **");
		$finish;
	end

	// random backpressure on the result stream
	always @(posedge clk) begin
		m_tready <= !jitter_on || ($urandom_range(99) >= 9);
	end

	// decode one raw byte; returns 1 when it yields a result
	function automatic logic deframe_byte(input logic [7:0] b, output deframed_t res);
		logic got;
		got = 1'b0;
		res = '0;
		case (link_mode)
		MODE_TYPE: begin
			// the type byte is always raw, even an escape byte
			esc_seen = 1'b0;
			if (b < TYPE_COUNT && b < MASK_WIDTH
				&& accept_mask[b[$clog2(MASK_WIDTH)-1:0]]) begin
				link_mode = MODE_PACKET;
				res = '{kind: KIND_START, value: b};
				got = 1'b1;
			end else begin
				link_mode = MODE_HUNT;
			end
		end
		MODE_PACKET: begin
			if (esc_seen) begin
				esc_seen = 1'b0;
				if (b == LITERAL_MARK) begin
					res = '{kind: KIND_DATA, value: ESC_BYTE};
					got = 1'b1;
				end else if (b == END_MARK) begin
					link_mode = MODE_HUNT;
					res = '{kind: KIND_END, value: 8'h00};
					got = 1'b1;
				end
				// any other escaped byte is dropped
			end else if (b == ESC_BYTE) begin
				esc_seen = 1'b1;
			end else begin
				res = '{kind: KIND_DATA, value: b};
				got = 1'b1;
			end
		end
		default: begin
			// hunting, the unused code behaves the same
			link_mode = MODE_HUNT;
			if (esc_seen) begin
				esc_seen = 1'b0;
				if (b == START_MARK)
					link_mode = MODE_TYPE;
			end else if (b == ESC_BYTE) begin
				esc_seen = 1'b1;
			end
		end
		endcase
		return got;
	endfunction

	// result check first, then prediction of the byte taken at this edge
	always @(posedge clk) begin : watch_streams
		deframed_t want;
		deframed_t seen;
		if (m_tvalid && m_tready) begin
			seen = '{kind: m_tuser, value: m_tdata};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual kind %0d value %h",
					$time, seen.kind, seen.value);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (seen.kind !== want.kind) begin
					$display("%0t: kind mismatch: expected %0d actual %0d", $time,
						want.kind, seen.kind);
					errors++;
				end
				if (seen.value !== want.value) begin
					$display("%0t: value mismatch: expected %h actual %h", $time,
						want.value, seen.value);
					errors++;
				end
				case (want.kind)
				KIND_START: starts_seen++;
				KIND_DATA:  data_seen++;
				default:    ends_seen++;
				endcase
			end
		end
		if (s_tvalid && s_tready) begin
			if (deframe_byte(s_tdata, want))
				pending_results.push_back(want);
		end
	end

	// one raw byte transfer, with an occasional gap before it
	task automatic send_byte(input logic [7:0] b);
		while (jitter_on && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_escaped(input logic [7:0] b);
		send_byte(ESC_BYTE);
		send_byte(b);
	endtask

	// stop sending until everything in flight has come out
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_type_mask(input logic [MASK_WIDTH-1:0] mask);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= mask;
		@(posedge clk);
		cfg_we <= 1'b0;
		accept_mask = mask;
		mask_writes++;
	endtask

	// after reset every type is disabled, so a start goes nowhere
	task automatic test_reset_mask;
		send_escaped(START_MARK);
		send_byte(8'h00);
		drain();
	endtask

	task automatic test_packet_basics;
		set_type_mask(16'h8001);
		send_escaped(START_MARK);
		send_byte(8'h0F);            // highest type, enabled
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_escaped(LITERAL_MARK);  // stuffed escape byte
		send_escaped(START_MARK);    // unknown escape, dropped
		send_escaped(ESC_BYTE);      // dropped, no new escape
		send_escaped(END_MARK);
		drain();
	endtask

	task automatic test_hunting_cases;
		// escaped escape byte is consumed, so the ff after it is plain
		send_escaped(ESC_BYTE);
		send_byte(START_MARK);
		send_byte(8'h00);
		// raw escape byte as type, type past the mask, disabled type
		send_escaped(START_MARK);
		send_byte(ESC_BYTE);
		send_escaped(START_MARK);
		send_byte(8'h10);
		send_escaped(START_MARK);
		send_byte(8'h01);
		drain();
	endtask

	task automatic send_payload_item;
		logic [7:0] b;
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			b = 8'($urandom_range(255));
			if (b == ESC_BYTE)
				send_escaped(LITERAL_MARK);
			else
				send_byte(b);
		end else if (pick < 80) begin
			send_escaped(LITERAL_MARK);
		end else if (pick < 88) begin
			do b = 8'($urandom_range(255)); while (b == LITERAL_MARK || b == END_MARK);
			send_escaped(b);
		end else begin
			case ($urandom_range(5))
			0: send_byte(8'h00);
			1: send_byte(8'hFE);
			2: send_byte(8'hFF);
			3: send_byte(8'h7F);
			4: send_byte(8'h80);
			default: send_byte(8'h01);
			endcase
		end
	endtask

	// a framed packet with random content; now and then cut short
	task automatic send_packet;
		logic [7:0] pkt_type;
		int pick;
		int len;
		pick = $urandom_range(99);
		if (pick < 80)
			pkt_type = 8'($urandom_range(TYPE_COUNT - 1));
		else if (pick < 90)
			pkt_type = 8'($urandom_range(255, 16));
		else
			pkt_type = ($urandom_range(1) != 0) ? ESC_BYTE : START_MARK;
		send_escaped(START_MARK);
		send_byte(pkt_type);
		len = $urandom_range(12);
		for (int i = 0; i < len; i++)
			send_payload_item();
		if ($urandom_range(99) < 88)
			send_escaped(END_MARK);
	endtask

	task automatic send_noise;
		int len;
		len = $urandom_range(6, 1);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
			0, 1, 2: send_byte(ESC_BYTE);
			3:       send_byte(START_MARK);
			default: send_byte(8'($urandom_range(255)));
			endcase
		end
	endtask

	task automatic test_random_traffic(input int target);
		logic [MASK_WIDTH-1:0] masks[8];
		int phase_end;
		masks = '{16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA,
			16'hFFFF, 16'h8001, 16'h0000, 16'h0000};
		masks[6] = MASK_WIDTH'($urandom_range(16'hFFFF));
		masks[7] = MASK_WIDTH'($urandom_range(16'hFFFF));
		for (int phase = 0; phase < 8; phase++) begin
			set_type_mask(masks[phase]);
			// one phase runs both streams flat out
			jitter_on = (phase != 4);
			phase_end = bytes_sent + target / 8;
			while (bytes_sent < phase_end) begin
				if ($urandom_range(99) < 80)
					send_packet();
				else
					send_noise();
			end
		end
		jitter_on = 1'b1;
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_mask();
		test_packet_basics();
		test_hunting_cases();
		test_random_traffic(920);

		// all stimulus in, wait out the pipeline
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d raw bytes under %0d mask writes", bytes_sent, mask_writes);
		$display("checked %0d starts, %0d data bytes, %0d ends, %0d errors",
			starts_seen, data_seen, ends_seen, errors);
		if (errors == 0) begin
			$display("** escaped_packet_deframer: PASSED **");
		end else begin
			$display("** escaped_packet_deframer: FAILED **");
		end
		$finish;
	end

endmodule
